/* hdl/tmbc_pkg.sv */
// Package for the tile map box collision resolver.
// Holds payload structs, state enum, constants. No dependencies.
package tmbc_pkg;
  localparam int MaxColumnsDef = 64;
  localparam int MaxRowsDef = 64;
  localparam int CoordBitsDef = 24;

  localparam logic [1:0] CfgCellWidth = 2'd0;
  localparam logic [1:0] CfgCellHeight = 2'd1;
  localparam logic [1:0] CfgMapColumns = 2'd2;
  localparam logic [1:0] CfgMapRows = 2'd3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam int FlagSolid = 0;
  localparam int FlagUp = 1;
  localparam int FlagDown = 2;
  localparam int FlagLeft = 3;
  localparam int FlagRight = 4;

  typedef struct packed {
    logic        operation;
    logic [5:0]  tile_column;
    logic [5:0]  tile_row;
    logic [4:0]  tile_flags;
    logic signed [CoordBitsDef-1:0] box_left;
    logic signed [CoordBitsDef-1:0] box_top;
    logic signed [CoordBitsDef-1:0] box_right;
    logic signed [CoordBitsDef-1:0] box_bottom;
  } in_item_t;

  typedef struct packed {
    logic        collided;
    logic signed [CoordBitsDef-1:0] push_x;
    logic signed [CoordBitsDef-1:0] push_y;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StDivX0, StDivY0, StDivX1, StDivY1, StSetup,
    StRead, StWait, StEval, StDone
  } state_e;

  // Status from divider to sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

/* hdl/tmbc_floor_div.sv */
// Iterative floor divider: signed dividend by unsigned 16-bit divisor.
// One quotient bit per cycle. Uses tmbc_pkg.
module tmbc_floor_div import tmbc_pkg::*; #(
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [CoordBits-1:0] dividend_i,
  input  logic [15:0]                 divisor_i,
  output div_stat_t                   stat_o,
  output logic signed [CoordBits:0]   quot_o
);
  localparam int CntW = $clog2(CoordBits + 1);
  logic [CoordBits-1:0] mag_q, mag_d, quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [16:0] shl;

  always_comb begin
    mag_d = mag_q; quo_d = quo_q; rem_d = rem_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    shl = {rem_q[15:0], mag_q[CoordBits-1]};
    if (start_i) begin
      neg_d = dividend_i[CoordBits-1];
      mag_d = neg_d ? CoordBits'(-dividend_i) : dividend_i;
      rem_d = '0; quo_d = '0; busy_d = 1'b1;
      cnt_d = CntW'(CoordBits);
    end else if (busy_q) begin
      mag_d = mag_q << 1;
      if (shl >= {1'b0, divisor_i}) begin
        rem_d = shl - {1'b0, divisor_i};
        quo_d = {quo_q[CoordBits-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[CoordBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (rem_q != '0) ? -$signed({1'b0, quo_q}) - 2'sd1
                             : -$signed({1'b0, quo_q});
    end else begin
      quot_o = $signed({1'b0, quo_q});
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
endmodule

/* hdl/tile_map_box_collision_resolve_core.sv */
// Tile map box collision resolver, top level.
// Write item: stored to tile memory in StDone if in range. Query item: four divides,
// then a StRead, StWait, StEval pass per covered tile through the tile memory read port.
// The input stalls until the result is taken; the next item can be taken in the cycle after.
// After reset a clearing pass over all MaxColumns*MaxRows entries runs before any
// item is accepted; configuration resets to 16.0 cells and a full map.
module tile_map_box_collision_resolve_core import tmbc_pkg::*; #(
  parameter int MaxColumns = MaxColumnsDef,
  parameter int MaxRows = MaxRowsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int CoordBits = CoordBitsDef;
  localparam int CW = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int RW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int Depth = MaxColumns * MaxRows;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WW = CoordBits + 18;  // wide working width

  logic [15:0] cw_q, ch_q;
  logic [6:0] cols_q, rows_q;
  state_e st_q, st_d;
  in_item_t item_q;
  logic [4:0] mem [Depth];
  logic [4:0] rd_q;
  logic [AW-1:0] clr_q;
  logic signed [CoordBits:0] minx_q, miny_q, maxx_q, maxy_q;
  logic [CW-1:0] x_q, xs_q, xe_q;
  logic [RW-1:0] y_q, ye_q;
  logic signed [WW-1:0] ival_q, bx_q, by_q;
  logic setx_q, sety_q;
  logic signed [WW-1:0] tl_q, tt_q;
  div_stat_t dstat;
  logic dstart;
  logic dstart_pend_q;
  logic empty_d;
  logic signed [CoordBits-1:0] dnum;
  logic [15:0] dden;
  logic signed [CoordBits:0] dq;
  logic [15:0] cwe, che;
  logic signed [WW-1:0] lim_c, lim_r;

  assign cwe = (cw_q == '0) ? 16'd1 : cw_q;
  assign che = (ch_q == '0) ? 16'd1 : ch_q;
  assign lim_c = (cols_q == '0) ? WW'(1) :
                 (cols_q > 7'(MaxColumns) && MaxColumns < 127) ? WW'(MaxColumns)
                 : WW'(cols_q);
  assign lim_r = (rows_q == '0) ? WW'(1) :
                 (rows_q > 7'(MaxRows) && MaxRows < 127) ? WW'(MaxRows)
                 : WW'(rows_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 16'd4096; ch_q <= 16'd4096; cols_q <= 7'd64; rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCellWidth:  cw_q <= cfg_data_i;
        CfgCellHeight: ch_q <= cfg_data_i;
        CfgMapColumns: cols_q <= cfg_data_i[6:0];
        CfgMapRows:    rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  tmbc_floor_div #(.CoordBits(CoordBits)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(dnum), .divisor_i(dden),
    .stat_o(dstat), .quot_o(dq)
  );

  logic in_acc, out_acc, div_go;
  assign in_stall_o = (st_q != StIdle) || out_valid_o;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign div_go = !dstat.busy && !dstat.done;

  always_comb begin
    dnum = item_q.box_left[CoordBits-1:0]; dden = cwe;
    unique case (st_q)
      StDivY0: begin dnum = item_q.box_top[CoordBits-1:0]; dden = che; end
      StDivX1: begin dnum = item_q.box_right[CoordBits-1:0]; dden = cwe; end
      StDivY1: begin dnum = item_q.box_bottom[CoordBits-1:0]; dden = che; end
      default: ;
    endcase
  end

  always_comb begin
    dstart = 1'b0;
    if ((st_q == StDivX0 || st_q == StDivY0 || st_q == StDivX1 || st_q == StDivY1)
        && div_go && !dstart_pend_q) dstart = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dstart_pend_q <= 1'b0;
    else if (dstart) dstart_pend_q <= 1'b1;
    else if (dstat.done) dstart_pend_q <= 1'b0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClear: if (clr_q == AW'(Depth - 1)) st_d = StIdle;
      StIdle:  if (in_acc) st_d = (in_item_i.operation == OpQuery) ? StDivX0 : StDone;
      StDivX0: if (dstat.done) st_d = StDivY0;
      StDivY0: if (dstat.done) st_d = StDivX1;
      StDivX1: if (dstat.done) st_d = StDivY1;
      StDivY1: if (dstat.done) st_d = StSetup;
      StSetup: st_d = empty_d ? StDone : StRead;
      StRead:  st_d = StWait;
      StWait:  st_d = StEval;
      StEval:  st_d = (x_q == xe_q && y_q == ye_q) ? StDone : StRead;
      StDone:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // clamp helpers
  function automatic logic signed [WW-1:0] clampv(logic signed [WW-1:0] v,
                                                  logic signed [WW-1:0] hi);
    logic signed [WW-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > hi - 1) r = hi - 1;
    return r;
  endfunction

  logic signed [WW-1:0] cminx, cminy, cmaxx, cmaxy;
  assign cminx = clampv(WW'(minx_q), lim_c);
  assign cmaxx = clampv(WW'(maxx_q), lim_c);
  assign cminy = clampv(WW'(miny_q), lim_r);
  assign cmaxy = clampv(WW'(maxy_q), lim_r);
  assign empty_d = (cminx > cmaxx) || (cminy > cmaxy);

  // Evaluation: candidates from the registered tile origin.
  logic signed [WW-1:0] x0, y0, x1, y1, up, dn, lf, rt, vy, vx;
  function automatic logic [WW-1:0] absw(logic signed [WW-1:0] v);
    return v[WW-1] ? WW'(-v) : WW'(v);
  endfunction
  assign x0 = WW'(item_q.box_left);
  assign y0 = WW'(item_q.box_top);
  assign x1 = WW'(item_q.box_right);
  assign y1 = WW'(item_q.box_bottom);
  assign up = rd_q[FlagUp] ? tt_q - y1 : -ival_q;
  assign dn = rd_q[FlagDown] ? tt_q + WW'(che) - y0 : ival_q;
  assign lf = rd_q[FlagLeft] ? tl_q - x1 : -ival_q;
  assign rt = rd_q[FlagRight] ? tl_q + WW'(cwe) - x0 : ival_q;
  assign vy = (absw(up) < absw(dn)) ? up : dn;
  assign vx = (absw(lf) < absw(rt)) ? lf : rt;

  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(item_q.tile_row) * AW'(MaxColumns) + AW'(item_q.tile_column);
  assign raddr = AW'(y_q) * AW'(MaxColumns) + AW'(x_q);

  always_ff @(posedge clk_i) begin
    if (st_q == StClear) mem[clr_q] <= '0;
    else if (st_q == StDone && item_q.operation == OpWrite &&
             32'(item_q.tile_column) < MaxColumns && 32'(item_q.tile_row) < MaxRows)
      mem[waddr] <= item_q.tile_flags;
    if (st_q == StRead) rd_q <= mem[raddr];
  end

  function automatic logic signed [CoordBits-1:0] sat(logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi, lo;
    hi = WW'((64'sd1 <<< (CoordBits - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return CoordBits'(hi);
    if (v < lo) return CoordBits'(lo);
    return CoordBits'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (out_acc) out_valid_o <= 1'b0;
      if (st_q == StDone) out_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      setx_q <= 1'b0; sety_q <= 1'b0;
      ival_q <= (WW'(in_item_i.box_right) - WW'(in_item_i.box_left) >
                 WW'(in_item_i.box_bottom) - WW'(in_item_i.box_top)) ?
                WW'(in_item_i.box_right) - WW'(in_item_i.box_left) :
                WW'(in_item_i.box_bottom) - WW'(in_item_i.box_top);
    end
    if (dstat.done) begin
      unique case (st_q)
        StDivX0: minx_q <= dq;
        StDivY0: miny_q <= dq;
        StDivX1: maxx_q <= dq;
        StDivY1: maxy_q <= dq;
        default: ;
      endcase
    end
    if (st_q == StSetup) begin
      bx_q <= ival_q; by_q <= ival_q;
      x_q <= CW'(cminx); xs_q <= CW'(cminx); xe_q <= CW'(cmaxx);
      y_q <= RW'(cminy); ye_q <= RW'(cmaxy);
    end
    if (st_q == StRead) begin
      tl_q <= $signed({{(WW-CW){1'b0}}, x_q}) * $signed({2'b0, cwe});
      tt_q <= $signed({{(WW-RW){1'b0}}, y_q}) * $signed({2'b0, che});
    end
    if (st_q == StEval) begin
      if (rd_q[FlagSolid]) begin
        if (absw(vy) < absw(vx)) begin
          if (absw(vy) < absw(by_q)) by_q <= vy;
          sety_q <= 1'b1;
        end else begin
          if (absw(vx) < absw(bx_q)) bx_q <= vx;
          setx_q <= 1'b1;
        end
      end
      if (x_q == xe_q) begin
        x_q <= xs_q; y_q <= y_q + 1'b1;
      end else x_q <= x_q + 1'b1;
    end
    if (st_q == StDone) begin
      out_item_o.collided <= (item_q.operation == OpQuery) && (setx_q || sety_q);
      out_item_o.push_x <= (item_q.operation == OpQuery && setx_q) ? sat(bx_q) : '0;
      out_item_o.push_y <= (item_q.operation == OpQuery && sety_q) ? sat(by_q) : '0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_acc) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> !dstat.busy) else $error("divider busy in idle");
endmodule
